// ===== design/sk512_pkg.sv =====
// shared types and constants for the skein-512 hash block
package sk512_pkg;

	localparam logic [63:0] PARITY    = 64'h1BD11BDAA9FC1A22;
	localparam logic [63:0] SCHEMA    = 64'h0000000133414853;
	localparam logic [63:0] T_FINAL   = 64'h8000000000000000;
	localparam logic [63:0] T_FIRST   = 64'h4000000000000000;
	localparam logic [63:0] T_CFG     = 64'h0400000000000000;
	localparam logic [63:0] T_MSG     = 64'h3000000000000000;
	localparam logic [63:0] T_OUT     = 64'h3F00000000000000;
	localparam int          NUM_ROUND = 72;

	typedef logic [63:0] word_t;
	typedef word_t [7:0] block_t;

	// queued job: one message block, with a flag for the final one
	typedef struct packed {
		block_t      msg;
		logic [6:0]  count;
		logic        first;
		logic        fin;
		logic        open;
		logic [9:0]  hbits;
	} job_t;

	function automatic logic [5:0] rot_amt(input logic [2:0] r, input logic [1:0] j);
		logic [5:0] v;
		v = 6'd0;
		case ({r, j})
			5'd0: v = 6'd46; 5'd1: v = 6'd36; 5'd2: v = 6'd19; 5'd3: v = 6'd37;
			5'd4: v = 6'd33; 5'd5: v = 6'd27; 5'd6: v = 6'd14; 5'd7: v = 6'd42;
			5'd8: v = 6'd17; 5'd9: v = 6'd49; 5'd10: v = 6'd36; 5'd11: v = 6'd39;
			5'd12: v = 6'd44; 5'd13: v = 6'd9; 5'd14: v = 6'd54; 5'd15: v = 6'd56;
			5'd16: v = 6'd39; 5'd17: v = 6'd30; 5'd18: v = 6'd34; 5'd19: v = 6'd24;
			5'd20: v = 6'd13; 5'd21: v = 6'd50; 5'd22: v = 6'd10; 5'd23: v = 6'd17;
			5'd24: v = 6'd25; 5'd25: v = 6'd29; 5'd26: v = 6'd39; 5'd27: v = 6'd43;
			5'd28: v = 6'd8; 5'd29: v = 6'd35; 5'd30: v = 6'd56; 5'd31: v = 6'd22;
			default: v = 6'd0;
		endcase
		return v;
	endfunction

	function automatic word_t rotl(input word_t x, input logic [5:0] n);
		return (x << n) | (x >> (7'd64 - {1'b0, n}));
	endfunction

endpackage

// ===== design/sk512_front.sv =====
// front end: byte collection into blocks, job generation
module sk512_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [7:0]         data_byte,
	input  logic               has_byte,
	input  logic               last_byte,
	input  logic               push,
	output logic               full,
	input  logic [9:0]         hbits,
	output sk512_pkg::job_t    job,
	output logic               job_valid,
	input  logic               job_ready
);
	logic [7:0]  buf_q [64];
	logic [6:0]  fill_q;
	logic        first_q;
	logic        open_q;
	logic        pend_q;   // a job is held for the queue
	logic        fin2_q;   // final job waiting behind a flushed full block
	sk512_pkg::job_t job_q;
	sk512_pkg::job_t fin_job_q;
	logic        take;
	logic        need_flush;

	assign full       = pend_q;
	assign take       = push && !pend_q;
	assign need_flush = has_byte && (fill_q == 7'd64);
	assign job        = job_q;
	assign job_valid  = pend_q;

	// zero-padded block image of the buffer, optionally plus the incoming byte
	function automatic sk512_pkg::block_t pack(input logic [7:0] b [64], input logic [6:0] n);
		sk512_pkg::block_t r;
		for (int i = 0; i < 64; i++)
			r[i/8][(i%8)*8 +: 8] = (7'(i) < n) ? b[i] : 8'd0;
		return r;
	endfunction

	logic [7:0] nb [64];
	logic [6:0] nfill;
	logic [5:0] wr_idx;
	sk512_pkg::job_t flush_job;
	sk512_pkg::job_t last_job;
	sk512_pkg::job_t open_job;
	always_comb begin
		nb     = buf_q;
		nfill  = need_flush ? 7'd0 : fill_q;
		wr_idx = nfill[5:0];
		if (has_byte) begin
			nb[wr_idx] = data_byte;
			nfill = nfill + 7'd1;
		end

		// full block pushed out by a further byte
		flush_job       = '0;
		flush_job.msg   = pack(buf_q, fill_q);
		flush_job.count = 7'd64;
		flush_job.first = first_q;
		flush_job.hbits = hbits;

		// final block, including the byte of this item
		last_job       = '0;
		last_job.msg   = pack(nb, nfill);
		last_job.count = nfill;
		last_job.first = open_q ? (first_q && !need_flush) : 1'b1;
		last_job.fin   = 1'b1;
		last_job.open  = !open_q;
		last_job.hbits = hbits;

		// message start only, no block yet
		open_job       = '0;
		open_job.first = 1'b1;
		open_job.open  = 1'b1;
		open_job.hbits = hbits;
	end

	always_ff @(posedge clk) begin
		if (take && has_byte) begin
			buf_q[wr_idx] <= data_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q    <= '0;
			first_q   <= 1'b1;
			open_q    <= 1'b0;
			pend_q    <= 1'b0;
			fin2_q    <= 1'b0;
			job_q     <= '0;
			fin_job_q <= '0;
		end else begin
			if (pend_q && job_ready) begin
				if (fin2_q) begin
					job_q  <= fin_job_q;
					fin2_q <= 1'b0;
				end else begin
					pend_q <= 1'b0;
				end
			end
			if (take) begin
				open_q <= !last_byte;
				fill_q <= last_byte ? 7'd0 : nfill;
				if (need_flush) begin
					job_q   <= flush_job;
					first_q <= last_byte;
					pend_q  <= 1'b1;
					if (last_byte) begin
						// final block follows the flushed one
						fin_job_q <= last_job;
						fin2_q    <= 1'b1;
					end
				end else if (last_byte) begin
					job_q   <= last_job;
					first_q <= 1'b1;
					pend_q  <= 1'b1;
				end else if (!open_q) begin
					job_q   <= open_job;
					first_q <= 1'b1;
					pend_q  <= 1'b1;
				end
			end
		end
	end
endmodule

// ===== design/sk512_back.sv =====
// back end: threefish-512 rounds, ubi chaining, digest output
module sk512_back (
	input  logic               clk,
	input  logic               arst_n,
	input  sk512_pkg::job_t    job,
	input  logic               job_valid,
	output logic               job_ready,
	output logic [63:0]        digest_word,
	output logic [2:0]         word_index,
	output logic               last_word,
	output logic               empty,
	input  logic               pop
);
	typedef enum logic [2:0] {IDLE, START, ROUND, DONE, EMIT} st_t;
	typedef enum logic [1:0] {P_CFG, P_MSG, P_OUT} ph_t;

	st_t st_q;
	ph_t ph_q;
	sk512_pkg::job_t job_q;
	sk512_pkg::word_t cv_q [8];
	sk512_pkg::word_t v_q [8];
	sk512_pkg::word_t m_q [8];
	sk512_pkg::word_t k_q [9];
	sk512_pkg::word_t t_q [3];
	sk512_pkg::word_t pos_q;
	logic [6:0] rnd_q;
	logic [2:0] widx_q;
	logic [3:0] nw_q;

	sk512_pkg::word_t va [8];
	sk512_pkg::word_t f [8];
	sk512_pkg::word_t vn [8];
	logic [4:0] s;
	logic [10:0] wsum;

	assign s = rnd_q[6:2];
	assign job_ready   = (st_q == IDLE);
	assign empty       = (st_q != EMIT);
	assign digest_word = cv_q[widx_q];
	assign word_index  = widx_q;
	assign last_word   = ({1'b0, widx_q} + 4'd1 == nw_q);
	assign wsum        = {1'b0, job_q.hbits} + 11'd63;

	// key schedule index, x up to 25
	function automatic logic [3:0] mod9(input logic [4:0] x);
		logic [4:0] r;
		r = x;
		if (r >= 5'd18) r = r - 5'd18;
		else if (r >= 5'd9) r = r - 5'd9;
		return r[3:0];
	endfunction

	// tweak schedule index, x up to 19
	function automatic logic [1:0] mod3(input logic [4:0] x);
		logic [4:0] r;
		r = x;
		if (r >= 5'd18) r = r - 5'd18;
		if (r >= 5'd9) r = r - 5'd9;
		if (r >= 5'd6) r = r - 5'd6;
		if (r >= 5'd3) r = r - 5'd3;
		return r[1:0];
	endfunction

	// one round per cycle, key injection every fourth
	always_comb begin
		logic [3:0] ki;
		logic [1:0] ti;
		ki = '0;
		ti = '0;
		va = v_q;
		if (rnd_q[1:0] == 2'd0) begin
			for (int i = 0; i < 8; i++) begin
				ki = mod9(s + 5'(i));
				va[i] = v_q[i] + k_q[ki];
			end
			ti = mod3(s);
			va[5] = va[5] + t_q[ti];
			ti = mod3(s + 5'd1);
			va[6] = va[6] + t_q[ti];
			va[7] = va[7] + 64'(s);
		end
		for (int j = 0; j < 4; j++) begin
			f[2*j]   = va[2*j] + va[2*j+1];
			f[2*j+1] = sk512_pkg::rotl(va[2*j+1], sk512_pkg::rot_amt(rnd_q[2:0], 2'(j)))
				^ f[2*j];
		end
		vn[0] = f[2]; vn[1] = f[1]; vn[2] = f[4]; vn[3] = f[7];
		vn[4] = f[6]; vn[5] = f[5]; vn[6] = f[0]; vn[7] = f[3];
	end

	// load key, tweak, message for one ubi step
	task automatic setup(input sk512_pkg::word_t key [8], input sk512_pkg::block_t msg,
		input sk512_pkg::word_t t0, input sk512_pkg::word_t t1);
		sk512_pkg::word_t par;
		par = sk512_pkg::PARITY;
		for (int i = 0; i < 8; i++) begin
			k_q[i] <= key[i];
			par = par ^ key[i];
			m_q[i] <= msg[i];
			v_q[i] <= msg[i];
		end
		k_q[8] <= par;
		t_q[0] <= t0;
		t_q[1] <= t1;
		t_q[2] <= t0 ^ t1;
		rnd_q  <= '0;
	endtask

	sk512_pkg::word_t zk [8];
	sk512_pkg::block_t cfgb;
	always_comb begin
		for (int i = 0; i < 8; i++) zk[i] = '0;
		cfgb = '0;
		cfgb[0] = sk512_pkg::SCHEMA;
		cfgb[1] = {54'd0, job_q.hbits};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= IDLE;
			ph_q   <= P_CFG;
			widx_q <= '0;
			nw_q   <= 4'd8;
			pos_q  <= '0;
		end else begin
			case (st_q)
				IDLE: begin
					if (job_valid) begin
						job_q <= job;
						st_q  <= START;
					end
				end
				START: begin
					if (job_q.open) begin
						ph_q <= P_CFG;
						setup(zk, cfgb, 64'd32,
							sk512_pkg::T_FIRST | sk512_pkg::T_FINAL | sk512_pkg::T_CFG);
						pos_q <= '0;
						st_q  <= ROUND;
					end else begin
						ph_q <= P_MSG;
						if (job_q.fin || job_q.count != 7'd0) begin
							setup(cv_q, job_q.msg, pos_q + 64'(job_q.count),
								sk512_pkg::T_MSG | (job_q.first ? sk512_pkg::T_FIRST : '0)
								| (job_q.fin ? sk512_pkg::T_FINAL : '0));
							pos_q <= pos_q + 64'(job_q.count);
							st_q  <= ROUND;
						end else begin
							st_q <= IDLE;
						end
					end
				end
				ROUND: begin
					if (rnd_q == 7'(sk512_pkg::NUM_ROUND)) begin
						for (int i = 0; i < 8; i++) cv_q[i] <= va[i] ^ m_q[i];
						st_q <= DONE;
					end else begin
						v_q   <= vn;
						rnd_q <= rnd_q + 7'd1;
					end
				end
				DONE: begin
					case (ph_q)
						P_CFG: begin
							job_q.open <= 1'b0;
							st_q <= START;
						end
						P_MSG: begin
							if (job_q.fin) begin
								ph_q <= P_OUT;
								setup(cv_q, '0, 64'd8,
									sk512_pkg::T_FIRST | sk512_pkg::T_FINAL | sk512_pkg::T_OUT);
								st_q <= ROUND;
							end else begin
								st_q <= IDLE;
							end
						end
						default: begin
							widx_q <= '0;
							if (wsum[10:6] == 5'd0) nw_q <= 4'd1;
							else if (wsum[10:6] > 5'd8) nw_q <= 4'd8;
							else nw_q <= wsum[9:6];
							st_q <= EMIT;
						end
					endcase
				end
				EMIT: begin
					if (pop) begin
						if (last_word) st_q <= IDLE;
						widx_q <= widx_q + 3'd1;
					end
				end
				default: st_q <= IDLE;
			endcase
		end
	end
endmodule

// ===== design/skein_512_hash_top.sv =====
// skein-512 hash top level: byte front end, job register, round engine
//
//  channel | signals                                   | transaction
//  in      | push, full, data_byte, has_byte, last_byte | one message byte or end mark
//  out     | pop, empty, digest_word, word_index, last_word | one digest word
//  cfg     | cfg_valid, cfg_ready, cfg_data             | hash_bits write
//
// each ubi compression takes a load step, then the round steps, then a finish step
// a message opens with a configuration compression, then one per full 64-byte block
// the final item costs two chained compressions, three when its byte spills past a full
// block or when it also opens the message, then one cycle per popped digest word
// full holds off input while a job waits for the engine, through both jobs of a spill
// reset is asynchronous, active low; hash_bits resets to 512
module skein_512_hash_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [7:0]  data_byte,
	input  logic        has_byte,
	input  logic        last_byte,
	input  logic        push,
	output logic        full,
	output logic [63:0] digest_word,
	output logic [2:0]  word_index,
	output logic        last_word,
	output logic        empty,
	input  logic        pop,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [9:0]  cfg_data
);
	logic [9:0] hbits_q;
	sk512_pkg::job_t job;
	logic job_valid, job_ready;

	// configuration register, always writable
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hbits_q <= 10'd512;
		end else if (cfg_valid) begin
			hbits_q <= cfg_data;
		end
	end

	sk512_front u_front (
		.clk, .arst_n, .data_byte, .has_byte, .last_byte, .push, .full,
		.hbits(hbits_q), .job, .job_valid, .job_ready
	);

	sk512_back u_back (
		.clk, .arst_n, .job, .job_valid, .job_ready,
		.digest_word, .word_index, .last_word, .empty, .pop
	);
endmodule

// ===== design/sk512_checker.sv =====
// port-level checks for the skein-512 top level
module sk512_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       empty,
	input logic       pop,
	input logic       last_word,
	input logic [2:0] word_index
);
	a_first_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && $past(empty) && !$past(!arst_n)) |-> word_index == 3'd0)
		else $error("first digest word not index 0");
	a_step: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && pop && !last_word) |=> (!empty))
		else $error("digest ended without last_word");
	a_done: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && pop && last_word) |=> empty)
		else $error("output after last_word");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> $stable(word_index))
		else $error("word changed while stalled");
endmodule

bind skein_512_hash_top sk512_checker u_chk (
	.clk, .arst_n, .empty, .pop, .last_word, .word_index
);

// ===== dv/testbench.sv =====
// self-checking testbench for the skein-512 hash top level
module testbench;

	// kinds of pending stimulus entries: a message item or a hash_bits write
	typedef enum logic {ENT_ITEM, ENT_CFG} entry_kind_t;

	typedef struct {
		entry_kind_t kind;
		logic [7:0]  byte_val;
		logic        has;
		logic        last;
		logic [9:0]  cfg_val;
	} entry_t;

	typedef struct {
		logic [63:0] digest;
		logic [2:0]  index;
		logic        last;
	} digest_exp_t;

	// cycles of quiet before a hash_bits write, covers an in-flight compression
	localparam int SETTLE_CYCLES = 300;

	// threefish-512 rotation amounts, four per round, eight-round cycle
	localparam int ROT_TBL [32] = '{
		46, 36, 19, 37, 33, 27, 14, 42, 17, 49, 36, 39, 44, 9, 54, 56,
		39, 30, 34, 24, 13, 50, 10, 17, 25, 29, 39, 43, 8, 35, 56, 22
	};
	localparam int WORD_PERM [8] = '{2, 1, 4, 7, 6, 5, 0, 3};

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic [7:0]  data_byte = 8'd0;
	logic        has_byte = 1'b0;
	logic        last_byte = 1'b0;
	logic        push = 1'b0;
	logic        full;
	logic [63:0] digest_word;
	logic [2:0]  word_index;
	logic        last_word;
	logic        empty;
	logic        pop = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [9:0]  cfg_data = 10'd0;

	skein_512_hash_top uut (
		.clk(clk), .arst_n(arst_n),
		.data_byte(data_byte), .has_byte(has_byte), .last_byte(last_byte),
		.push(push), .full(full),
		.digest_word(digest_word), .word_index(word_index), .last_word(last_word),
		.empty(empty), .pop(pop),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	// stimulus waiting for the driver, and digest words waiting for the monitor
	entry_t      pending_q[$];
	digest_exp_t digest_q[$];
	int          mismatches = 0;

	// hash state mirrored from the block
	logic [9:0]   hash_bits_cur = 10'd512;
	logic [63:0]  chain_val [8];
	logic [511:0] msg_block;
	int           fill;
	logic [63:0]  position;
	logic         first_blk;
	logic         msg_open;

	// one ubi step: chain = threefish(key = chain, tweak, block) ^ block
	function automatic void ubi_compress(input logic [511:0] blk, input logic [63:0] t0,
			input logic [63:0] t1);
		logic [63:0] k [9];
		logic [63:0] tw [3];
		logic [63:0] m [8];
		logic [63:0] v [8];
		logic [63:0] f [8];
		logic [63:0] a;
		int r;
		int s;
		k[8] = sk512_pkg::PARITY;
		for (int i = 0; i < 8; i++) begin
			m[i] = blk[64*i +: 64];
			k[i] = chain_val[i];
			k[8] ^= k[i];
			v[i] = m[i];
		end
		tw[0] = t0; tw[1] = t1; tw[2] = t0 ^ t1;
		for (int d = 0; d <= sk512_pkg::NUM_ROUND; d++) begin
			if (d % 4 == 0) begin
				s = d / 4;
				for (int i = 0; i < 8; i++) v[i] += k[(s + i) % 9];
				v[5] += tw[s % 3];
				v[6] += tw[(s + 1) % 3];
				v[7] += 64'(s);
			end
			if (d == sk512_pkg::NUM_ROUND) break;
			for (int i = 0; i < 4; i++) begin
				r = ROT_TBL[(d % 8) * 4 + i];
				a = v[2*i] + v[2*i+1];
				f[2*i] = a;
				f[2*i+1] = ((v[2*i+1] << r) | (v[2*i+1] >> (64 - r))) ^ a;
			end
			for (int i = 0; i < 8; i++) v[i] = f[WORD_PERM[i]];
		end
		for (int i = 0; i < 8; i++) chain_val[i] = v[i] ^ m[i];
	endfunction

	function automatic void compress_buffer(input logic fin);
		logic [63:0] t1;
		t1 = sk512_pkg::T_MSG | (first_blk ? sk512_pkg::T_FIRST : 64'd0)
			| (fin ? sk512_pkg::T_FINAL : 64'd0);
		position += 64'(fill);
		ubi_compress(msg_block, position, t1);
		first_blk = 1'b0;
		fill = 0;
	endfunction

	// absorb one accepted item and queue the digest words it causes
	function automatic void absorb_item(input entry_t e);
		logic [511:0] cfg_blk;
		int nwords;
		digest_exp_t x;
		if (!msg_open) begin
			cfg_blk = '0;
			cfg_blk[63:0] = sk512_pkg::SCHEMA;
			cfg_blk[127:64] = 64'(hash_bits_cur);
			for (int i = 0; i < 8; i++) chain_val[i] = '0;
			ubi_compress(cfg_blk, 64'd32,
				sk512_pkg::T_FIRST | sk512_pkg::T_FINAL | sk512_pkg::T_CFG);
			position = '0;
			first_blk = 1'b1;
			fill = 0;
			msg_open = 1'b1;
		end
		if (e.has) begin
			if (fill >= 64) compress_buffer(1'b0);
			msg_block[8*(fill % 64) +: 8] = e.byte_val;
			fill++;
		end
		if (!e.last) return;
		for (int i = fill; i < 64; i++) msg_block[8*i +: 8] = 8'd0;
		compress_buffer(1'b1);
		ubi_compress('0, 64'd8, sk512_pkg::T_FIRST | sk512_pkg::T_FINAL | sk512_pkg::T_OUT);
		msg_open = 1'b0;
		msg_block = '0;
		position = '0;
		first_blk = 1'b1;
		nwords = (int'(hash_bits_cur) + 63) / 64;
		if (nwords < 1) nwords = 1;
		if (nwords > 8) nwords = 8;
		for (int i = 0; i < nwords; i++) begin
			x.digest = chain_val[i];
			x.index = 3'(i);
			x.last = (i + 1 == nwords);
			digest_q.push_back(x);
		end
	endfunction

	// ---------------- driver ----------------
	// bursts of random length with random gaps; hash_bits writes only once
	// every digest word is back and the block has been quiet for a while
	int burst_left = 8;
	int gap_left = 0;
	int quiet_cycles = 0;

	always @(posedge clk) begin
		logic   next_push;
		logic   next_cfg;
		logic   took_item;
		entry_t head;
		if (arst_n) begin
			next_push = 1'b0;
			next_cfg = 1'b0;
			took_item = 1'b0;
			if (push && !full) begin
				absorb_item(pending_q.pop_front());
				took_item = 1'b1;
				burst_left--;
				if (burst_left <= 0) begin
					burst_left = $urandom_range(1, 40);
					// no-gap stretches are common
					gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 15);
				end
			end
			if (cfg_valid && cfg_ready) begin
				head = pending_q.pop_front();
				hash_bits_cur = head.cfg_val;
				took_item = 1'b1;
			end
			quiet_cycles <= (took_item || digest_q.size() != 0) ? 0 : quiet_cycles + 1;

			if (push && full) begin
				next_push = 1'b1;
			end else if (cfg_valid && !cfg_ready) begin
				next_cfg = 1'b1;
			end else if (gap_left > 0) begin
				gap_left--;
			end else if (pending_q.size() != 0) begin
				head = pending_q[0];
				if (head.kind == ENT_ITEM) begin
					next_push = 1'b1;
					data_byte <= head.byte_val;
					has_byte <= head.has;
					last_byte <= head.last;
				end else if (quiet_cycles >= SETTLE_CYCLES && !took_item) begin
					next_cfg = 1'b1;
					cfg_data <= head.cfg_val;
				end
			end
			push <= next_push;
			cfg_valid <= next_cfg;
		end
	end

	// ---------------- monitor ----------------
	// pop pattern switches among steady pop, random stalls, short and long stalls
	int stall_mode = 0;
	int mon_cycle = 0;

	always @(posedge clk) begin
		digest_exp_t x;
		logic        bad;
		if (arst_n) begin
			if (pop && !empty) begin
				if (digest_q.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected digest word %h index %0d", digest_word, word_index);
				end else begin
					x = digest_q.pop_front();
					bad = (digest_word !== x.digest) || (word_index !== x.index) ||
						(last_word !== x.last);
					if (bad) begin
						mismatches++;
						if (mismatches <= 10)
							$display("digest mismatch: exp %h/%0d/%0b got %h/%0d/%0b",
								x.digest, x.index, x.last, digest_word, word_index, last_word);
					end
				end
			end
			mon_cycle++;
			if (mon_cycle % 256 == 0) stall_mode = $urandom_range(0, 3);
			case (stall_mode)
				0: pop <= 1'b1;
				1: pop <= ($urandom_range(0, 3) != 0);
				2: pop <= (mon_cycle % 7) >= 2;
				default: pop <= (mon_cycle % 64) >= 40;
			endcase
		end
	end

	// ---------------- stimulus ----------------
	int item_count = 0;

	task automatic add_item(input logic [7:0] b, input logic h, input logic l);
		entry_t e;
		e.kind = ENT_ITEM; e.byte_val = b; e.has = h; e.last = l; e.cfg_val = '0;
		pending_q.push_back(e);
		item_count++;
	endtask

	task automatic add_cfg(input logic [9:0] v);
		entry_t e;
		e.kind = ENT_CFG; e.byte_val = '0; e.has = 1'b0; e.last = 1'b0; e.cfg_val = v;
		pending_q.push_back(e);
	endtask

	// n bytes; the end mark rides on the last byte or on a byteless item
	task automatic add_message(input int n, input logic sep_end, input logic noise);
		for (int i = 0; i < n; i++) begin
			if (noise && $urandom_range(0, 9) == 0) add_item(8'($urandom), 1'b0, 1'b0);
			add_item(8'($urandom), 1'b1, (i == n - 1) && !sep_end);
		end
		if (sep_end || n == 0) add_item(8'($urandom), 1'b0, 1'b1);
	endtask

	initial begin
		int n;
		for (int i = 0; i < 8; i++) chain_val[i] = '0;
		msg_block = '0;
		fill = 0;
		position = '0;
		first_blk = 1'b1;
		msg_open = 1'b0;

		// directed: empty message, byte extremes, full block boundary
		add_message(0, 1'b0, 1'b0);
		add_item(8'h00, 1'b1, 1'b1);
		add_item(8'hFF, 1'b1, 1'b1);
		add_item(8'hA5, 1'b0, 1'b0);  // opens a message without data
		add_item(8'h5A, 1'b1, 1'b0);
		add_item(8'h3C, 1'b0, 1'b1);
		add_cfg(10'd0);
		add_message(1, 1'b0, 1'b0);
		add_cfg(10'd1023);
		add_message(2, 1'b1, 1'b0);
		add_cfg(10'd1);
		add_message(64, 1'b0, 1'b0);
		add_cfg(10'd64);
		add_message(65, 1'b1, 1'b0);
		add_cfg(10'd65);
		// hash_bits changed while a message is open
		add_item(8'h11, 1'b1, 1'b0);
		add_cfg(10'd256);
		add_item(8'h22, 1'b1, 1'b1);
		add_cfg(10'd512);

		// random messages, mostly short, some across one or two block edges
		while (item_count < 320) begin
			case ($urandom_range(0, 9))
				0: n = 0;
				1, 2: n = $urandom_range(60, 70);
				3: n = $urandom_range(126, 130);
				default: n = $urandom_range(1, 20);
			endcase
			add_message(n, $urandom_range(0, 3) == 0, 1'b1);
			if ($urandom_range(0, 3) == 0) begin
				case ($urandom_range(0, 3))
					0: add_cfg(10'd512);
					1: add_cfg(10'($urandom_range(1, 64)));
					default: add_cfg(10'($urandom));
				endcase
			end
		end

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_q.size() != 0 || digest_q.size() != 0) @(posedge clk);
		repeat (400) @(posedge clk);
		if (mismatches == 0 && digest_q.size() == 0)
			$display("skein_512_hash_top regression: pass");
		else
			$display("skein_512_hash_top regression: fail");
		$finish;
	end

	// watchdog
	initial begin
		#20000000;
		$display("skein_512_hash_top regression: fail");
		$finish;
	end

endmodule

// ===== skein_512_hash_top.f =====
design/sk512_pkg.sv
design/sk512_front.sv
design/sk512_back.sv
design/skein_512_hash_top.sv
design/sk512_checker.sv
dv/testbench.sv
